FILE: design/tklt_pkg.sv
package tklt_pkg;

  // Field widths of the item formats.
  localparam int DUR_W  = 40;
  localparam int TAG_W  = 16;
  localparam int RIDX_W = 4;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int AVG_W  = 40;
  localparam int KEPT_W = 5;
  localparam int MP_W   = 5;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 184;

  localparam int              MAX_ENTRIES_DEF = 16;
  localparam logic [MP_W-1:0] MP_RESET        = 5'd16;

  // Command codes carried on in_tuser.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic              is_add;
    logic [DUR_W-1:0]  dur;
    logic [TAG_W-1:0]  tag;
    logic [RIDX_W-1:0] rd_idx;
  } rank_req_t;

  typedef struct packed {
    logic              busy;
    logic [KEPT_W-1:0] kept;
    logic              entry_valid;
    entry_t            entry;
  } rank_rsp_t;

endpackage

FILE: design/top_k_latency_tracker_top.sv
// Latency tracker that counts duration samples, keeps their saturating total
// and truncated average, and holds the largest durations with their tags in a
// list ranked from largest down. An item with in_tuser at the add code brings
// a sample; an item with the read code changes nothing. Either kind returns
// exactly one result item carrying the count, the total, the average, the
// number of entries held and the entry at the requested rank, with out_tuser
// high when that rank holds an entry (duration and tag read as zero
// otherwise). The number of entries kept is set by a single register written
// through cfg_we and cfg_wdata; the user is to write it only while the block
// is idle, which the block itself does not enforce. Zero acts as one and
// values above MAX_ENTRIES act as MAX_ENTRIES. Lowering it below the number
// already held does not trim the list. The block works on one item at a time:
// a read only fetches the entry at the requested rank, while an add also runs
// the bit-serial divider for the average, which produces one quotient bit per
// cycle over the 48-bit total, and the insertion walk through the entry
// memory, which reads and moves one entry at a time, in a read state and a
// compare state, through its single read and write port. Both run side by
// side, and the result is loaded once both are done; the next item can be
// accepted as soon as the result appears. A finished result waits in an
// output register, so a new item is accepted while the previous result has
// not yet been taken.
module top_k_latency_tracker_top #(
  parameter int MAX_ENTRIES = tklt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // duration_us [39:0], tag [55:40], read_index [59:56], zero padding above.
  input  logic [tklt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd [0].
  input  logic                             in_tuser,
  // Result items.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_count [31:0], total_us [79:32], avg_us [119:80],
  // kept_count [124:120], entry_duration_us [164:125], entry_tag [180:165],
  // zero padding above.
  output logic [tklt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // entry_valid [0].
  output logic                             out_tuser,
  // Configuration: max_points.
  input  logic                             cfg_we,
  input  logic [tklt_pkg::MP_W-1:0]        cfg_wdata
);
  import tklt_pkg::*;

  localparam int OUT_PAD = OUT_TDATA_W - (CNT_W + SUM_W + AVG_W + KEPT_W + DUR_W + TAG_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KICK = 4'b0010,
    S_WAIT = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t             st_r, st_nxt;
  logic [MP_W-1:0]    max_points_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W:0]     sum_wide;
  logic               cmd_r;
  logic [DUR_W-1:0]   dur_r;
  logic [TAG_W-1:0]   tag_r;
  logic [RIDX_W-1:0]  ridx_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  logic               in_acc;
  logic               is_add_in;
  logic [DUR_W-1:0]   in_dur;
  logic [TAG_W-1:0]   in_tag;
  logic [RIDX_W-1:0]  in_ridx;
  logic               out_free;
  logic               load;

  logic               div_start;
  logic               div_busy;
  logic [AVG_W-1:0]   avg;
  rank_req_t          rank_req;
  rank_rsp_t          rank_rsp;

  assign in_dur    = in_tdata[DUR_W-1:0];
  assign in_tag    = in_tdata[DUR_W +: TAG_W];
  assign in_ridx   = in_tdata[DUR_W + TAG_W +: RIDX_W];
  assign is_add_in = in_tuser == CMD_ADD;

  assign in_tready = st_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign load      = (st_r == S_LOAD) && out_free;

  // The count and the total saturate rather than wrap.
  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(in_dur);
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (in_acc && is_add_in) begin
      cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
      sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = S_KICK;
        end
      end
      S_KICK: begin
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!div_busy && !rank_rsp.busy) begin
          st_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      max_points_r <= MP_RESET;
      cnt_r        <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      if (cfg_we) begin
        max_points_r <= cfg_wdata;
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tuser;
      dur_r  <= in_dur;
      tag_r  <= in_tag;
      ridx_r <= in_ridx;
    end
    if (load) begin
      out_tdata_r <= {{OUT_PAD{1'b0}}, rank_rsp.entry.tag, rank_rsp.entry.dur,
                      rank_rsp.kept, avg, sum_r, cnt_r};
      out_tuser_r <= rank_rsp.entry_valid;
    end
  end

  // On an add both units start together, once count and total are updated.
  assign div_start = (st_r == S_KICK) && (cmd_r == CMD_ADD);

  assign rank_req.start  = st_r == S_KICK;
  assign rank_req.is_add = cmd_r == CMD_ADD;
  assign rank_req.dur    = dur_r;
  assign rank_req.tag    = tag_r;
  assign rank_req.rd_idx = ridx_r;

  tklt_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (avg)
  );

  tklt_rank_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_rank_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_points (max_points_r),
    .req        (rank_req),
    .rsp        (rank_rsp)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: design/tklt_divider.sv
module tklt_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tklt_pkg::SUM_W-1:0] dividend,
  input  logic [tklt_pkg::CNT_W-1:0] divisor,
  output logic                       busy,
  output logic [tklt_pkg::AVG_W-1:0] quotient
);
  import tklt_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Restoring division: the dividend shifts out of q_r as quotient bits shift in.
  assign trial = {rem_r, q_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      q_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      q_r    <= dividend;
    end else if (busy_r) begin
      q_r    <= {q_r[SUM_W-2:0], ge};
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = (|q_r[SUM_W-1:AVG_W]) ? '1 : q_r[AVG_W-1:0];

endmodule

FILE: design/tklt_rank_store.sv
module tklt_rank_store #(
  parameter int MAX_ENTRIES = tklt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tklt_pkg::MP_W-1:0] max_points,
  input  tklt_pkg::rank_req_t       req,
  output tklt_pkg::rank_rsp_t       rsp
);
  import tklt_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HELD_W = $clog2(MAX_ENTRIES + 1);
  localparam int LW     = (HELD_W > MP_W) ? HELD_W : MP_W;
  localparam int CW     = (HELD_W > RIDX_W) ? HELD_W : RIDX_W;

  typedef enum logic [5:0] {
    R_IDLE  = 6'b000001,
    R_CHK   = 6'b000010,
    R_RD    = 6'b000100,
    R_CMP   = 6'b001000,
    R_PUT   = 6'b010000,
    R_FETCH = 6'b100000
  } rstate_t;

  rstate_t           st_r, st_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              strict_r, strict_nxt;
  logic              inc_r, inc_nxt;
  logic              valid_r, valid_nxt;
  logic [DUR_W-1:0]  d_r, d_nxt;
  logic [TAG_W-1:0]  t_r, t_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;

  entry_t            mem_r [MAX_ENTRIES];
  entry_t            rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wa;
  entry_t            wd;

  logic [LW-1:0]     mp_ext;
  logic [LW-1:0]     lim_ext;
  logic [HELD_W-1:0] lim;
  logic              full;
  logic              lt;
  logic              eq;
  logic              move;
  logic              valid_now;

  // Effective limit: zero acts as one, anything above the depth as the depth.
  assign mp_ext  = LW'(max_points);
  assign lim_ext = (mp_ext == '0) ? LW'(1) :
                   (mp_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : mp_ext;
  assign lim     = HELD_W'(lim_ext);
  assign full    = held_r >= lim;

  // The one comparator, shared by the full-list check and the insertion walk.
  assign lt   = rd_data_r.dur < d_r;
  assign eq   = rd_data_r.dur == d_r;
  assign move = lt | (strict_r & eq);

  assign valid_now = CW'(ridx_r) < CW'(held_r);

  always_comb begin
    st_nxt     = st_r;
    held_nxt   = held_r;
    i_nxt      = i_r;
    pos_nxt    = pos_r;
    strict_nxt = strict_r;
    inc_nxt    = inc_r;
    valid_nxt  = valid_r;
    d_nxt      = d_r;
    t_nxt      = t_r;
    ridx_nxt   = ridx_r;
    rd_en      = 1'b0;
    rd_addr    = i_r;
    we         = 1'b0;
    wa         = pos_r;
    wd         = '{dur: d_r, tag: t_r};
    unique case (st_r)
      R_IDLE: begin
        if (req.start) begin
          d_nxt    = req.dur;
          t_nxt    = req.tag;
          ridx_nxt = req.rd_idx;
          if (!req.is_add) begin
            st_nxt = R_FETCH;
          end else if (!full) begin
            strict_nxt = 1'b0;
            inc_nxt    = 1'b1;
            if (held_r == '0) begin
              pos_nxt = '0;
              st_nxt  = R_PUT;
            end else begin
              i_nxt  = IDX_W'(held_r - 1'b1);
              st_nxt = R_RD;
            end
          end else begin
            strict_nxt = 1'b1;
            inc_nxt    = 1'b0;
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(held_r - 1'b1);
            st_nxt     = R_CHK;
          end
        end
      end
      R_CHK: begin
        if (lt) begin
          if (held_r == HELD_W'(1)) begin
            pos_nxt = '0;
            st_nxt  = R_PUT;
          end else begin
            i_nxt  = IDX_W'(held_r - 2'd2);
            st_nxt = R_RD;
          end
        end else begin
          st_nxt = R_FETCH;
        end
      end
      R_RD: begin
        rd_en   = 1'b1;
        rd_addr = i_r;
        st_nxt  = R_CMP;
      end
      R_CMP: begin
        if (move) begin
          we = 1'b1;
          wa = IDX_W'(i_r + 1'b1);
          wd = rd_data_r;
          if (i_r == '0) begin
            pos_nxt = '0;
            st_nxt  = R_PUT;
          end else begin
            i_nxt  = i_r - 1'b1;
            st_nxt = R_RD;
          end
        end else begin
          pos_nxt = IDX_W'(i_r + 1'b1);
          st_nxt  = R_PUT;
        end
      end
      R_PUT: begin
        we = 1'b1;
        if (inc_r) begin
          held_nxt = held_r + 1'b1;
        end
        st_nxt = R_FETCH;
      end
      R_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = valid_now ? IDX_W'(ridx_r) : '0;
        valid_nxt = valid_now;
        st_nxt    = R_IDLE;
      end
      default: begin
        st_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= R_IDLE;
      held_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      held_r  <= held_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    pos_r    <= pos_nxt;
    strict_r <= strict_nxt;
    inc_r    <= inc_nxt;
    d_r      <= d_nxt;
    t_r      <= t_nxt;
    ridx_r   <= ridx_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rsp.busy        = st_r != R_IDLE;
  assign rsp.kept        = KEPT_W'(held_r);
  assign rsp.entry_valid = valid_r;
  assign rsp.entry       = valid_r ? rd_data_r : '0;

endmodule
